@@ rtl/sct_pkg.sv @@
package sct_pkg;

    // Token kinds carried on token_kind.
    localparam logic [3:0] KIND_WORD    = 4'd0;
    localparam logic [3:0] KIND_SEMI    = 4'd1;
    localparam logic [3:0] KIND_AMP     = 4'd2;
    localparam logic [3:0] KIND_PIPE    = 4'd3;
    localparam logic [3:0] KIND_LESS    = 4'd4;
    localparam logic [3:0] KIND_GREATER = 4'd5;
    localparam logic [3:0] KIND_APPEND  = 4'd6;
    localparam logic [3:0] KIND_END     = 4'd7;
    localparam logic [3:0] KIND_ERROR   = 4'd8;

    // Depth of the queue between the front and the back.
    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_input;
    } item_t;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] lexeme_byte;
        logic       token_done;
        logic [3:0] token_kind;
        logic       last;
    } res_t;

    // Everything one input byte produces: none, one or two results.
    typedef struct packed {
        logic [1:0] count;
        res_t       r0;
        res_t       r1;
    } bundle_t;

endpackage

@@ rtl/sct_front.sv @@
module sct_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sct_pkg::item_t    item,
    output logic              full,
    input  logic              q_full,
    output logic              q_wr,
    output sct_pkg::bundle_t  q_wdata
);

    localparam logic [7:0] ChDot   = 8'h2E;
    localparam logic [7:0] ChDash  = 8'h2D;
    localparam logic [7:0] ChUnder = 8'h5F;
    localparam logic [7:0] ChSlash = 8'h2F;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChSemi  = 8'h3B;
    localparam logic [7:0] ChAmp   = 8'h26;
    localparam logic [7:0] ChPipe  = 8'h7C;
    localparam logic [7:0] ChLess  = 8'h3C;
    localparam logic [7:0] ChGt    = 8'h3E;
    localparam logic [7:0] ChQuote = 8'h22;
    localparam logic [7:0] ChBsl   = 8'h5C;

    typedef enum logic [2:0] {
        ST_START,
        ST_WORD,
        ST_ESC,
        ST_QUOTE,
        ST_GT,
        ST_ERR
    } state_t;

    typedef struct packed {
        logic          has;
        sct_pkg::res_t res;
        state_t        nxt;
    } start_t;

    state_t           state_reg;
    state_t           state_next;
    sct_pkg::bundle_t bundle;
    start_t           st;
    logic             accept;
    logic [7:0]       c;
    logic             eoi;

    function automatic logic word_byte(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h30 && b <= 8'h39) || b == ChDot || b == ChDash ||
               b == ChUnder || b == ChSlash;
    endfunction

    function automatic sct_pkg::res_t mk(input logic bv, input logic [7:0] b,
                                         input logic done, input logic [3:0] kind);
        sct_pkg::res_t r;
        r.byte_valid  = bv;
        r.lexeme_byte = bv ? b : 8'd0;
        r.token_done  = done;
        r.token_kind  = done ? kind : sct_pkg::KIND_WORD;
        r.last        = 1'b0;
        return r;
    endfunction

    // Handling of a byte as seen from the start state.
    function automatic start_t from_start(input logic [7:0] b, input logic e);
        start_t s;
        s.has = 1'b1;
        s.nxt = ST_START;
        s.res = mk(1'b0, 8'd0, 1'b1, sct_pkg::KIND_END);
        if (!e) begin
            if (word_byte(b)) begin
                s.nxt = ST_WORD;
                s.res = mk(1'b1, b, 1'b0, sct_pkg::KIND_WORD);
            end
            else begin
                case (b)
                    ChSpace: s.has = 1'b0;
                    ChSemi:  s.res = mk(1'b1, b, 1'b1, sct_pkg::KIND_SEMI);
                    ChAmp:   s.res = mk(1'b1, b, 1'b1, sct_pkg::KIND_AMP);
                    ChPipe:  s.res = mk(1'b1, b, 1'b1, sct_pkg::KIND_PIPE);
                    ChLess:  s.res = mk(1'b1, b, 1'b1, sct_pkg::KIND_LESS);
                    ChGt:
                    begin
                        s.nxt = ST_GT;
                        s.res = mk(1'b1, b, 1'b0, sct_pkg::KIND_WORD);
                    end
                    ChQuote:
                    begin
                        s.has = 1'b0;
                        s.nxt = ST_QUOTE;
                    end
                    ChBsl:
                    begin
                        s.has = 1'b0;
                        s.nxt = ST_ESC;
                    end
                    default:
                    begin
                        s.nxt = ST_ERR;
                        s.res = mk(1'b0, 8'd0, 1'b1, sct_pkg::KIND_ERROR);
                    end
                endcase
            end
        end
        return s;
    endfunction

    assign c      = item.char_in;
    assign eoi    = item.end_of_input;
    assign full   = q_full;
    assign accept = push && !q_full;
    assign st     = from_start(c, eoi);

    always_comb
    begin
        state_next   = state_reg;
        bundle.count = 2'd0;
        bundle.r0    = '0;
        bundle.r1    = '0;
        unique case (state_reg)
            ST_WORD:
            begin
                if (!eoi && word_byte(c)) begin
                    bundle.count = 2'd1;
                    bundle.r0    = mk(1'b1, c, 1'b0, sct_pkg::KIND_WORD);
                end
                else if (!eoi && c == ChBsl) begin
                    state_next = ST_ESC;
                end
                else begin
                    // The word closes first, then the byte is taken as at start.
                    bundle.r0    = mk(1'b0, 8'd0, 1'b1, sct_pkg::KIND_WORD);
                    bundle.r1    = st.res;
                    bundle.count = st.has ? 2'd2 : 2'd1;
                    state_next   = st.nxt;
                end
            end
            ST_ESC:
            begin
                bundle.count = 2'd1;
                if (eoi) begin
                    state_next = ST_START;
                    bundle.r0  = mk(1'b0, 8'd0, 1'b1, sct_pkg::KIND_ERROR);
                end
                else begin
                    state_next = ST_WORD;
                    bundle.r0  = mk(1'b1, c, 1'b0, sct_pkg::KIND_WORD);
                end
            end
            ST_QUOTE:
            begin
                bundle.count = 2'd1;
                if (eoi) begin
                    state_next = ST_START;
                    bundle.r0  = mk(1'b0, 8'd0, 1'b1, sct_pkg::KIND_ERROR);
                end
                else if (c == ChQuote) begin
                    state_next = ST_START;
                    bundle.r0  = mk(1'b0, 8'd0, 1'b1, sct_pkg::KIND_WORD);
                end
                else begin
                    bundle.r0 = mk(1'b1, c, 1'b0, sct_pkg::KIND_WORD);
                end
            end
            ST_GT:
            begin
                if (!eoi && c == ChGt) begin
                    state_next   = ST_START;
                    bundle.count = 2'd1;
                    bundle.r0    = mk(1'b1, c, 1'b1, sct_pkg::KIND_APPEND);
                end
                else begin
                    bundle.r0    = mk(1'b0, 8'd0, 1'b1, sct_pkg::KIND_GREATER);
                    bundle.r1    = st.res;
                    bundle.count = st.has ? 2'd2 : 2'd1;
                    state_next   = st.nxt;
                end
            end
            ST_ERR:
            begin
                if (eoi) begin
                    state_next = ST_START;
                end
            end
            default:
            begin
                bundle.r0    = st.res;
                bundle.count = st.has ? 2'd1 : 2'd0;
                state_next   = st.nxt;
            end
        endcase
        if (bundle.count == 2'd1) begin
            bundle.r0.last = 1'b1;
        end
        if (bundle.count == 2'd2) begin
            bundle.r1.last = 1'b1;
        end
    end

    assign q_wr    = accept && (bundle.count != 2'd0);
    assign q_wdata = bundle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_START;
        end
        else if (accept) begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/sct_queue.sv @@
module sct_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  sct_pkg::bundle_t  wdata,
    output logic              q_full,
    input  logic              rd,
    output sct_pkg::bundle_t  rdata,
    output logic              q_empty
);

    sct_pkg::bundle_t                mem_reg [sct_pkg::QDepth];
    logic [sct_pkg::QPtrW-1:0]       wr_ptr_reg;
    logic [sct_pkg::QPtrW-1:0]       rd_ptr_reg;
    logic [sct_pkg::QCntW-1:0]       count_reg;
    logic [sct_pkg::QPtrW-1:0]       wr_ptr_next;
    logic [sct_pkg::QPtrW-1:0]       rd_ptr_next;
    logic [sct_pkg::QCntW-1:0]       count_next;

    localparam logic [sct_pkg::QPtrW-1:0] LastPtr = sct_pkg::QPtrW'(sct_pkg::QDepth - 1);
    localparam logic [sct_pkg::QCntW-1:0] FullCnt = sct_pkg::QCntW'(sct_pkg::QDepth);

    assign q_full  = (count_reg == FullCnt);
    assign q_empty = (count_reg == '0);
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr) begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd) begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr && !rd) begin
            count_next = count_reg + 1'b1;
        end
        else if (rd && !wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/sct_back.sv @@
module sct_back (
    input  logic              clk,
    input  logic              rst_n,
    input  sct_pkg::bundle_t  q_rdata,
    input  logic              q_empty,
    output logic              q_rd,
    output sct_pkg::res_t     result,
    output logic              empty,
    input  logic              pop
);

    sct_pkg::res_t out_reg;
    logic          out_valid_reg;
    logic          sel_reg;
    sct_pkg::res_t out_next;
    logic          out_valid_next;
    logic          sel_next;
    logic          load;
    logic          head_last;

    // The output register takes the next result whenever it is free or being taken.
    assign load      = !q_empty && (!out_valid_reg || pop);
    assign head_last = sel_reg || (q_rdata.count == 2'd1);
    assign q_rd      = load && head_last;

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        sel_next       = sel_reg;
        if (load) begin
            out_next       = sel_reg ? q_rdata.r1 : q_rdata.r0;
            out_valid_next = 1'b1;
            sel_next       = !head_last;
        end
        else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
        end
        else begin
            out_valid_reg <= out_valid_next;
            sel_reg       <= sel_next;
        end
    end

    assign result = out_reg;
    assign empty  = !out_valid_reg;

endmodule

@@ rtl/shell_command_tokenizer.sv @@
// Channel   Ports                     Request moves when
// input     push, full, item          push high and full low
// result    empty, pop, result        pop high and empty low
//
// A byte is taken in every cycle while the queue between front and back has room.
// Each byte yields zero, one or two results; the back hands out one result per
// cycle while pop is held, from its output register. A result is registered in
// the queue and then in the output register before it appears.
// Reset returns the lexer to its start state and empties the queue and output.
// A stalled result side fills the four-entry queue, after which full rises.
module shell_command_tokenizer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  sct_pkg::item_t item,
    output logic           empty,
    input  logic           pop,
    output sct_pkg::res_t  result
);

    logic             q_wr;
    logic             q_rd;
    logic             q_full;
    logic             q_empty;
    sct_pkg::bundle_t q_wdata;
    sct_pkg::bundle_t q_rdata;

    sct_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .item    (item),
        .full    (full),
        .q_full  (q_full),
        .q_wr    (q_wr),
        .q_wdata (q_wdata)
    );

    sct_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wdata   (q_wdata),
        .q_full  (q_full),
        .rd      (q_rd),
        .rdata   (q_rdata),
        .q_empty (q_empty)
    );

    sct_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_rdata (q_rdata),
        .q_empty (q_empty),
        .q_rd    (q_rd),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

    a_no_write_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        q_wr |-> !q_full)
        else $error("queue written while full");

    a_no_read_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
        q_rd |-> !q_empty)
        else $error("queue read while empty");

    a_bundle_count : assert property (@(posedge clk) disable iff (!rst_n)
        q_wr |-> (q_wdata.count == 2'd1 || q_wdata.count == 2'd2))
        else $error("bundle with bad result count queued");

    a_last_marks_bundle_end : assert property (@(posedge clk) disable iff (!rst_n)
        q_wr && q_wdata.count == 2'd2 |-> !q_wdata.r0.last && q_wdata.r1.last)
        else $error("last flag misplaced in two-result bundle");

endmodule

@@ test/tb_shell_command_tokenizer.sv @@
module tb_shell_command_tokenizer;

    localparam int CYCLE_LIMIT = 400000;
    localparam int BYTES_PER_PHASE = 250;

    // Bytes that the lexer treats specially.
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_LESS   = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_SLASH  = 8'h2F;

    localparam string WORD_CHARS =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.-_/";
    localparam string OP_CHARS = ";&|<>";

    typedef enum logic [2:0] {
        LEX_START,
        LEX_WORD,
        LEX_ESCAPE,
        LEX_QUOTE,
        LEX_GT_WAIT,
        LEX_SKIP
    } lex_state_t;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           push;
    logic           full;
    sct_pkg::item_t item;
    logic           empty;
    logic           pop;
    sct_pkg::res_t  result;

    lex_state_t    lex_state;
    sct_pkg::res_t step_tokens[$];
    sct_pkg::res_t expected_tokens[$];
    sct_pkg::res_t want;

    int send_idle_pct;
    int recv_idle_pct;
    int cycle_count;
    int error_count;
    int bytes_accepted;
    int bytes_skipped;
    int lines_sent;
    int results_checked;
    int tokens_done;
    int error_tokens;
    int append_tokens;

    shell_command_tokenizer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------------------------------------------------------- prediction

    function automatic bit is_word_char(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == CH_DOT || c == CH_DASH ||
               c == CH_USCORE || c == CH_SLASH;
    endfunction

    task automatic emit_token(bit bv, logic [7:0] b, bit done, logic [3:0] kind);
        sct_pkg::res_t r;
        r.byte_valid  = bv;
        r.lexeme_byte = bv ? b : 8'h00;
        r.token_done  = done;
        r.token_kind  = done ? kind : sct_pkg::KIND_WORD;
        r.last        = 1'b0;
        step_tokens.push_back(r);
    endtask

    task automatic lex_from_start(logic [7:0] c, logic eoi);
        lex_state = LEX_START;
        if (eoi)
            emit_token(1'b0, 8'h00, 1'b1, sct_pkg::KIND_END);
        else if (is_word_char(c))
        begin
            lex_state = LEX_WORD;
            emit_token(1'b1, c, 1'b0, sct_pkg::KIND_WORD);
        end
        else
        begin
            case (c)
                CH_SPACE: ;
                CH_SEMI:  emit_token(1'b1, c, 1'b1, sct_pkg::KIND_SEMI);
                CH_AMP:   emit_token(1'b1, c, 1'b1, sct_pkg::KIND_AMP);
                CH_PIPE:  emit_token(1'b1, c, 1'b1, sct_pkg::KIND_PIPE);
                CH_LESS:  emit_token(1'b1, c, 1'b1, sct_pkg::KIND_LESS);
                CH_GT:
                begin
                    lex_state = LEX_GT_WAIT;
                    emit_token(1'b1, c, 1'b0, sct_pkg::KIND_WORD);
                end
                CH_QUOTE:  lex_state = LEX_QUOTE;
                CH_BSLASH: lex_state = LEX_ESCAPE;
                default:
                begin
                    lex_state = LEX_SKIP;
                    emit_token(1'b0, 8'h00, 1'b1, sct_pkg::KIND_ERROR);
                end
            endcase
        end
    endtask

    task automatic predict_tokens(logic [7:0] c, logic eoi);
        step_tokens.delete();
        bytes_accepted++;
        if (lex_state == LEX_SKIP && !eoi)
            bytes_skipped++;
        case (lex_state)
            LEX_WORD:
            begin
                if (!eoi && is_word_char(c))
                    emit_token(1'b1, c, 1'b0, sct_pkg::KIND_WORD);
                else if (!eoi && c == CH_BSLASH)
                    lex_state = LEX_ESCAPE;
                else
                begin
                    emit_token(1'b0, 8'h00, 1'b1, sct_pkg::KIND_WORD);
                    lex_from_start(c, eoi);
                end
            end
            LEX_ESCAPE:
            begin
                if (eoi)
                begin
                    lex_state = LEX_START;
                    emit_token(1'b0, 8'h00, 1'b1, sct_pkg::KIND_ERROR);
                end
                else
                begin
                    lex_state = LEX_WORD;
                    emit_token(1'b1, c, 1'b0, sct_pkg::KIND_WORD);
                end
            end
            LEX_QUOTE:
            begin
                if (eoi)
                begin
                    lex_state = LEX_START;
                    emit_token(1'b0, 8'h00, 1'b1, sct_pkg::KIND_ERROR);
                end
                else if (c == CH_QUOTE)
                begin
                    lex_state = LEX_START;
                    emit_token(1'b0, 8'h00, 1'b1, sct_pkg::KIND_WORD);
                end
                else
                    emit_token(1'b1, c, 1'b0, sct_pkg::KIND_WORD);
            end
            LEX_GT_WAIT:
            begin
                if (!eoi && c == CH_GT)
                begin
                    lex_state = LEX_START;
                    emit_token(1'b1, c, 1'b1, sct_pkg::KIND_APPEND);
                end
                else
                begin
                    emit_token(1'b0, 8'h00, 1'b1, sct_pkg::KIND_GREATER);
                    lex_from_start(c, eoi);
                end
            end
            LEX_SKIP:
            begin
                if (eoi)
                    lex_state = LEX_START;
            end
            default: lex_from_start(c, eoi);
        endcase
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i])
            expected_tokens.push_back(step_tokens[i]);
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(string msg);
        error_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic compare_field(string name, int got, int exp_val);
        if (got != exp_val)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, exp_val));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_tokens.size() == 0)
                report_mismatch("result request arrived with nothing expected");
            else
            begin
                want = expected_tokens.pop_front();
                results_checked++;
                if (want.token_done)
                begin
                    tokens_done++;
                    if (want.token_kind == sct_pkg::KIND_ERROR)
                        error_tokens++;
                    if (want.token_kind == sct_pkg::KIND_APPEND)
                        append_tokens++;
                end
                compare_field("byte_valid", int'(result.byte_valid), int'(want.byte_valid));
                compare_field("lexeme_byte", int'(result.lexeme_byte),
                              int'(want.lexeme_byte));
                compare_field("token_done", int'(result.token_done), int'(want.token_done));
                compare_field("token_kind", int'(result.token_kind), int'(want.token_kind));
                compare_field("last", int'(result.last), int'(want.last));
            end
        end
    end

    // The receiver stalls at random; the rate follows the current phase.
    always @(negedge clk)
        pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);

    // ---------------------------------------------------------------- stimulus

    // Called at a falling edge; returns at the falling edge after acceptance
    // with push still high, so back-to-back requests follow without a gap.
    task automatic send_item(logic [7:0] c, logic eoi);
        // Each cycle the sender may idle, at the rate of the current phase.
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        item.char_in      = c;
        item.end_of_input = eoi;
        push              = 1'b1;
        do
            @(posedge clk);
        while (full);
        predict_tokens(c, eoi);
        @(negedge clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    task automatic end_line();
        send_item(8'($urandom_range(255)), 1'b1);
        lines_sent++;
    endtask

    task automatic wait_for_drain();
        push = 1'b0;
        while (expected_tokens.size() != 0)
            @(negedge clk);
        // Allow a margin once every expected result has been checked.
        repeat (6) @(negedge clk);
    endtask

    task automatic test_directed();
        // Leading spaces, a word cut short by an operator, then end of line.
        send_text("  a;");
        send_item(8'h00, 1'b1);
        // Empty quotes, plain text right after a closing quote, and end of
        // line straight after a backslash.
        send_text("\"\"x\\");
        send_item(8'hFF, 1'b1);
        lines_sent += 2;
        // Append, a greater-than resolved by another operator, and one
        // resolved by the end of the line.
        send_text(">>>|>");
        end_line();
        // End of line inside quotes, with the top byte as quoted content.
        send_item(CH_QUOTE, 1'b0);
        send_item(8'hFF, 1'b0);
        end_line();
        // An unexpected byte, a byte that is ignored, then a silent end.
        send_item(8'h00, 1'b0);
        send_item(8'h7F, 1'b0);
        end_line();
        // Escaped high byte inside a word.
        send_text("&<\\");
        send_item(8'h80, 1'b0);
        send_item(8'hFF, 1'b1);
        lines_sent++;
    endtask

    task automatic send_random_line();
        int n_parts;
        int pick;
        int len;
        logic [7:0] b;
        n_parts = $urandom_range(1, 6);
        repeat (n_parts)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                len = $urandom_range(1, 6);
                repeat (len)
                begin
                    if ($urandom_range(99) < 12)
                    begin
                        send_item(CH_BSLASH, 1'b0);
                        send_item(8'($urandom_range(255)), 1'b0);
                    end
                    else
                        send_item(WORD_CHARS[$urandom_range(WORD_CHARS.len() - 1)], 1'b0);
                end
            end
            else if (pick < 50)
            begin
                send_item(CH_QUOTE, 1'b0);
                len = $urandom_range(0, 5);
                repeat (len)
                begin
                    do
                        b = 8'($urandom_range(255));
                    while (b == CH_QUOTE);
                    send_item(b, 1'b0);
                end
                // Now and then the quote is left open to the end of the line.
                if ($urandom_range(99) < 90)
                    send_item(CH_QUOTE, 1'b0);
            end
            else if (pick < 75)
            begin
                b = OP_CHARS[$urandom_range(OP_CHARS.len() - 1)];
                send_item(b, 1'b0);
                if (b == CH_GT && $urandom_range(1) == 1)
                    send_item(CH_GT, 1'b0);
            end
            else if (pick < 90)
            begin
                len = $urandom_range(1, 3);
                repeat (len) send_item(CH_SPACE, 1'b0);
            end
            else
                send_item(8'($urandom_range(255)), 1'b0);
            if ($urandom_range(1) == 1)
                send_item(CH_SPACE, 1'b0);
        end
        if ($urandom_range(99) < 5)
            send_item(CH_BSLASH, 1'b0);
        end_line();
    endtask

    task automatic test_random_lines(int sender_pct, int receiver_pct);
        int target;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        target = bytes_accepted + BYTES_PER_PHASE;
        while (bytes_accepted < target)
            send_random_line();
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        item = '0;
        lex_state = LEX_START;
        send_idle_pct = 11;
        recv_idle_pct = 73;
        cycle_count = 0;
        error_count = 0;
        bytes_accepted = 0;
        bytes_skipped = 0;
        lines_sent = 0;
        results_checked = 0;
        tokens_done = 0;
        error_tokens = 0;
        append_tokens = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_lines(11, 73);
        // The sender holds off here until every result has come back.
        wait_for_drain();
        test_random_lines(73, 11);
        wait_for_drain();
        test_random_lines(0, 0);
        wait_for_drain();

        $display("Tokenised %0d command lines: %0d bytes and line ends, %0d skipped after errors.",
                 lines_sent, bytes_accepted, bytes_skipped);
        $display("Checked %0d results: %0d tokens ended, %0d of them errors and %0d appends.",
                 results_checked, tokens_done, error_tokens, append_tokens);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
